@@ sv/json_string_unescape_utf8_defines.svh @@
// ============================================================================
// json string unescape assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ============================================================================
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// same-cycle implication
`define JSU_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define JSU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/jsu_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// jsu_pkg
// beat types, job descriptor and result kind codes of the string unescaper
// ============================================================================
package jsu_pkg;

    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_DONE  = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam int CP_W = 21;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       text_ends;
    } t_in_beat;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] result_kind;
        logic       last_of_run;
    } t_out_beat;

    typedef enum logic [2:0] {
        JK_NONE  = 3'd0,
        JK_CP    = 3'd1,
        JK_RAW   = 3'd2,
        JK_DONE  = 3'd3,
        JK_ERROR = 3'd4
    } t_job_kind;

    // optional replacement char first, then the main part
    typedef struct packed {
        logic            fffd;
        t_job_kind       kind;
        logic [CP_W-1:0] value;
    } t_job;

endpackage

@@ sv/jsu_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// jsu_front
// escape and surrogate state machine; turns each input beat into at most one job
// ============================================================================
`include "json_string_unescape_utf8_defines.svh"

module jsu_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  jsu_pkg::t_in_beat i_in,
    output logic            o_job_valid,
    output jsu_pkg::t_job   o_job
);
    import jsu_pkg::*;

    typedef enum logic [5:0] {
        PH_PLAIN   = 6'b000001,
        PH_ESC     = 6'b000010,
        PH_HEX1    = 6'b000100,
        PH_HIGH    = 6'b001000,
        PH_HIGH_BS = 6'b010000,
        PH_HEX2    = 6'b100000
    } t_phase;

    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [7:0] t;
        t = 8'h00;
        if (c >= 8'h30 && c <= 8'h39) begin
            return {1'b1, c[3:0]};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            t = c - 8'h57;
            return {1'b1, t[3:0]};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            t = c - 8'h37;
            return {1'b1, t[3:0]};
        end
        return 5'd0;
    endfunction

    function automatic logic [8:0] esc_map(input logic [7:0] c);
        logic [8:0] r;
        unique case (c)
            8'h22:   r = {1'b1, 8'h22};
            8'h5C:   r = {1'b1, 8'h5C};
            8'h2F:   r = {1'b1, 8'h2F};
            8'h6E:   r = {1'b1, 8'h0A};
            8'h74:   r = {1'b1, 8'h09};
            8'h72:   r = {1'b1, 8'h0D};
            8'h62:   r = {1'b1, 8'h08};
            8'h66:   r = {1'b1, 8'h0C};
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    t_phase      r_phase, n_phase;
    logic [1:0]  r_cnt,   n_cnt;
    logic [15:0] r_acc,   n_acc;
    logic [9:0]  r_pend,  n_pend;

    logic [7:0]      b;
    logic [4:0]      hx;
    logic [8:0]      esc;
    logic [15:0]     acc_full;
    logic            is_quote, is_bs, is_u, pv, v_high, v_low;
    logic [CP_W-1:0] cp_pair;
    t_job            job;

    assign b        = i_in.data_byte;
    assign hx       = hex_digit(b);
    assign esc      = esc_map(b);
    assign acc_full = {r_acc[11:0], hx[3:0]};
    assign is_quote = (b == 8'h22);
    assign is_bs    = (b == 8'h5C);
    assign is_u     = (b == 8'h75);
    assign pv       = (r_phase == PH_HIGH) || (r_phase == PH_HIGH_BS) || (r_phase == PH_HEX2);
    assign v_high   = (acc_full[15:10] == 6'b110110);
    assign v_low    = (acc_full[15:10] == 6'b110111);
    assign cp_pair  = CP_W'(21'h10000) + {1'b0, r_pend, acc_full[9:0]};

    always_comb begin
        n_phase    = r_phase;
        n_cnt      = r_cnt;
        n_acc      = r_acc;
        n_pend     = r_pend;
        job        = '0;
        job.kind   = JK_NONE;
        if (i_in.text_ends) begin
            job.fffd = pv;
            job.kind = JK_ERROR;
            n_phase  = PH_PLAIN;
            n_cnt    = 2'd0;
        end else begin
            unique case (r_phase)
                PH_ESC: begin
                    if (is_u) begin
                        n_phase = PH_HEX1;
                        n_cnt   = 2'd0;
                        n_acc   = 16'd0;
                    end else if (esc[8]) begin
                        n_phase   = PH_PLAIN;
                        job.kind  = JK_RAW;
                        job.value = CP_W'(esc[7:0]);
                    end else begin
                        n_phase  = PH_PLAIN;
                        n_cnt    = 2'd0;
                        job.kind = JK_ERROR;
                    end
                end
                PH_HEX1, PH_HEX2: begin
                    if (!hx[4]) begin
                        job.fffd = pv;
                        job.kind = JK_ERROR;
                        n_phase  = PH_PLAIN;
                        n_cnt    = 2'd0;
                    end else if (r_cnt != 2'd3) begin
                        n_acc = acc_full;
                        n_cnt = r_cnt + 2'd1;
                    end else if (r_phase == PH_HEX2 && v_low) begin
                        job.kind  = JK_CP;
                        job.value = cp_pair;
                        n_phase   = PH_PLAIN;
                        n_cnt     = 2'd0;
                    end else begin
                        job.fffd = (r_phase == PH_HEX2);
                        n_acc    = 16'd0;
                        n_cnt    = 2'd0;
                        if (v_high) begin
                            n_pend  = acc_full[9:0];
                            n_phase = PH_HIGH;
                        end else begin
                            n_phase   = PH_PLAIN;
                            job.kind  = JK_CP;
                            job.value = v_low ? CP_W'(16'hFFFD) : CP_W'(acc_full);
                        end
                    end
                end
                PH_HIGH: begin
                    if (is_bs) begin
                        n_phase = PH_HIGH_BS;
                    end else begin
                        job.fffd = 1'b1;
                        n_phase  = PH_PLAIN;
                        if (is_quote) begin
                            job.kind = JK_DONE;
                            n_cnt    = 2'd0;
                        end else begin
                            job.kind  = JK_RAW;
                            job.value = CP_W'(b);
                        end
                    end
                end
                PH_HIGH_BS: begin
                    if (is_u) begin
                        n_phase = PH_HEX2;
                        n_cnt   = 2'd0;
                        n_acc   = 16'd0;
                    end else begin
                        job.fffd = 1'b1;
                        n_phase  = PH_PLAIN;
                        if (esc[8]) begin
                            job.kind  = JK_RAW;
                            job.value = CP_W'(esc[7:0]);
                        end else begin
                            job.kind = JK_ERROR;
                            n_cnt    = 2'd0;
                        end
                    end
                end
                default: begin
                    n_phase = PH_PLAIN;
                    if (is_quote) begin
                        job.kind = JK_DONE;
                        n_cnt    = 2'd0;
                    end else if (is_bs) begin
                        n_phase = PH_ESC;
                    end else begin
                        job.kind  = JK_RAW;
                        job.value = CP_W'(b);
                    end
                end
            endcase
        end
    end

    assign o_job       = job;
    assign o_job_valid = job.fffd || (job.kind != JK_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PLAIN;
            r_cnt   <= 2'd0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
    end

    `JSU_ASSERT_NEXT(a_end_goes_plain, i_clk, i_rst_n, i_accept && i_in.text_ends, r_phase == PH_PLAIN, "text end did not return to plain text")
    `JSU_ASSERT_NOW(a_error_ends_string, i_clk, i_rst_n, i_accept && job.kind == JK_ERROR, n_phase == PH_PLAIN && n_cnt == 2'd0, "error left escape state behind")

endmodule

@@ sv/jsu_queue.sv @@
`timescale 1ns / 1ps
// ============================================================================
// jsu_queue
// small job queue between the escape decoder and the byte expander
// ============================================================================
`include "json_string_unescape_utf8_defines.svh"

module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_job i_wdata,
    output logic          o_full,
    output logic          o_valid,
    output jsu_pkg::t_job o_rdata,
    input  logic          i_pop
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job          r_mem [DEPTH];
    logic [AW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rdata = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_wdata;
        end
    end

    `JSU_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH), "job queue overflow")

endmodule

@@ sv/jsu_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// jsu_back
// expands one job into its utf-8 beats and presents them one per cycle while i_pop is high
// ============================================================================
`include "json_string_unescape_utf8_defines.svh"

module jsu_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  jsu_pkg::t_job       i_job,
    output logic                o_job_pop,
    output logic                o_empty,
    output jsu_pkg::t_out_beat  o_beat,
    input  logic                i_pop
);
    import jsu_pkg::*;

    localparam int NB = 6;

    logic [7:0] r_bytes [NB];
    logic [1:0] r_kinds [NB];
    logic [2:0] r_cnt, r_idx;
    logic       r_valid;

    logic [7:0] m_byte [4];
    logic [1:0] m_kind;
    logic [2:0] m_len;
    logic [7:0] e_byte [NB];
    logic [1:0] e_kind [NB];
    logic [2:0] e_len;
    logic [CP_W-1:0] cp;
    logic       last, load;

    assign cp = i_job.value;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            m_byte[i] = 8'h00;
        end
        m_kind = KIND_DATA;
        m_len  = 3'd0;
        case (i_job.kind)
            JK_CP: begin
                if (cp < CP_W'(21'h80)) begin
                    m_byte[0] = cp[7:0];
                    m_len     = 3'd1;
                end else if (cp < CP_W'(21'h800)) begin
                    m_byte[0] = 8'hC0 | {3'b000, cp[10:6]};
                    m_byte[1] = 8'h80 | {2'b00, cp[5:0]};
                    m_len     = 3'd2;
                end else if (cp < CP_W'(21'h10000)) begin
                    m_byte[0] = 8'hE0 | {4'h0, cp[15:12]};
                    m_byte[1] = 8'h80 | {2'b00, cp[11:6]};
                    m_byte[2] = 8'h80 | {2'b00, cp[5:0]};
                    m_len     = 3'd3;
                end else begin
                    m_byte[0] = 8'hF0 | {5'b00000, cp[20:18]};
                    m_byte[1] = 8'h80 | {2'b00, cp[17:12]};
                    m_byte[2] = 8'h80 | {2'b00, cp[11:6]};
                    m_byte[3] = 8'h80 | {2'b00, cp[5:0]};
                    m_len     = 3'd4;
                end
            end
            JK_RAW: begin
                m_byte[0] = cp[7:0];
                m_len     = 3'd1;
            end
            JK_DONE: begin
                m_kind = KIND_DONE;
                m_len  = 3'd1;
            end
            JK_ERROR: begin
                m_kind = KIND_ERROR;
                m_len  = 3'd1;
            end
            default: begin
                m_len = 3'd0;
            end
        endcase

        for (int i = 0; i < NB; i++) begin
            e_byte[i] = 8'h00;
            e_kind[i] = KIND_DATA;
        end
        if (i_job.fffd) begin
            // replacement char U+FFFD, then at most three main bytes
            e_byte[0] = 8'hEF;
            e_byte[1] = 8'hBF;
            e_byte[2] = 8'hBD;
            e_byte[3] = m_byte[0];
            e_byte[4] = m_byte[1];
            e_byte[5] = m_byte[2];
            e_kind[3] = m_kind;
            e_len     = m_len + 3'd3;
        end else begin
            for (int i = 0; i < 4; i++) begin
                e_byte[i] = m_byte[i];
            end
            e_kind[0] = m_kind;
            e_len     = m_len;
        end
    end

    assign last      = (r_idx == r_cnt - 3'd1);
    assign load      = i_job_valid && (!r_valid || (i_pop && last));
    assign o_job_pop = load;
    assign o_empty   = !r_valid;

    assign o_beat.out_byte    = r_bytes[r_idx];
    assign o_beat.result_kind = r_kinds[r_idx];
    assign o_beat.last_of_run = last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= 3'd0;
            r_idx   <= 3'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_cnt   <= e_len;
            r_idx   <= 3'd0;
        end else if (r_valid && i_pop) begin
            if (last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            for (int i = 0; i < NB; i++) begin
                r_bytes[i] <= e_byte[i];
                r_kinds[i] <= e_kind[i];
            end
        end
    end

    `JSU_ASSERT_NOW(a_idx_in_run, i_clk, i_rst_n, r_valid, r_idx < r_cnt, "beat index past end of run")
    `JSU_ASSERT_NOW(a_marker_is_last, i_clk, i_rst_n, r_valid && r_kinds[r_idx] != KIND_DATA, last, "done or error beat is not last of run")

endmodule

@@ sv/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps
// ============================================================================
// json_string_unescape_utf8
// json string body unescaper with utf-8 output
// ============================================================================
// usage:
//   input queue: drive i_in_beat and raise push; a beat is taken on a clock
//   edge with push high and full low. one beat is one raw byte of the string
//   body starting after the opening quote, or a text end marker.
//   result queue: while empty is low, o_out_beat holds the oldest result; it
//   is taken on an edge with pop high. each input beat yields 0 to 6 results,
//   the last of them flagged by last_of_run.
//   path: a taken beat is written to the job queue and from there loaded
//   into the byte expander's registers, which present its results.
//   throughput: one input beat per cycle while each yields at most one
//   result and pop stays high; results leave at one per cycle while pop is
//   high, set by the byte expander, and beats that expand to several
//   results fill the job queue (QUEUE_DEPTH jobs) until full rises.
//   reset: synchronous, active low; the decoder returns to plain text and
//   both queues are emptied.
//   a stalled receiver holds the current result; input keeps flowing until
//   the job queue fills.
// ============================================================================

module json_string_unescape_utf8 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               push,
    output logic               full,
    input  jsu_pkg::t_in_beat  i_in_beat,
    output logic               empty,
    input  logic               pop,
    output jsu_pkg::t_out_beat o_out_beat
);
    import jsu_pkg::*;

    logic accept;
    logic f_job_valid;
    t_job f_job;
    logic q_full, q_valid, q_pop;
    t_job q_job;

    assign full   = q_full;
    assign accept = push && !q_full;

    jsu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_in        (i_in_beat),
        .o_job_valid (f_job_valid),
        .o_job       (f_job)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && f_job_valid),
        .i_wdata (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_rdata (q_job),
        .i_pop   (q_pop)
    );

    jsu_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_empty     (empty),
        .o_beat      (o_out_beat),
        .i_pop       (pop)
    );

endmodule
